// ===== rtl/core/tsm_pkg.sv =====
// tsm_pkg: shared constants, types and state encoding for the timestamp merge block
// no dependencies; imported by every rtl/core module except tsm_ram
`timescale 1ns / 1ps

package tsm_pkg;

    localparam int CAPACITY    = 64;
    localparam int PTS_W       = 48;
    localparam int PTS_PORT_W  = 48;
    localparam int HANDLE_W    = 32;
    localparam int SCALE_W     = 16;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int ENTRY_W     = PTS_W + HANDLE_W;
    localparam int PROD_W      = PTS_W + SCALE_W + 1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(48);

    localparam logic [1:0] OP_PUSH_A = 2'd0;
    localparam logic [1:0] OP_PUSH_V = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_AUDIO = 2'd1;
    localparam logic [1:0] KIND_VIDEO = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SRCH,
        ST_SRCH_CMP,
        ST_CHK,
        ST_CHK_CMP,
        ST_SHIFT,
        ST_POP_RD,
        ST_POP_MUL,
        ST_POP_PICK,
        ST_POP_SHIFT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic srch_init;
        logic srch_read;
        logic srch_upd;
        logic chk_read;
        logic ovr_write;
        logic set_drop;
        logic shift_init;
        logic shift_step;
        logic insert;
        logic pop_read;
        logic pop_mul;
        logic pop_pick;
        logic pop_step;
        logic pop_dec;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       srch_done;
        logic       pos_lt_fill;
        logic       key_eq;
        logic       full;
        logic       shift_done;
        logic       pop_any;
        logic       pop_done;
        logic       out_free;
    } sts_t;

endpackage

// ===== rtl/core/two_queue_timestamp_merge.sv =====
// two_queue_timestamp_merge: top level, sequencer plus datapath
// depends on tsm_pkg, tsm_ctrl, tsm_dp, tsm_ram
`timescale 1ns / 1ps

// Two sorted frame stores (audio, video) of 64 entries each, held in one ram apiece.
// One transaction is worked at a time. A push does a binary search (up to 6 probes
// below 64 entries, 7 at 64), one compare read when the position is below the fill,
// then shifts the tail up one entry per cycle; an overwrite or a drop ends without a
// shift. A pop reads both heads, multiplies the video key by the configured scale,
// picks, then shifts the winning store down one entry per cycle; when both stores
// are empty it ends without a shift. An unused opcode goes straight to the result.
// The single ram write port per store sets the shift rate. A new transaction is taken
// while the previous result waits in the output register; the next one then waits
// until that result is accepted.
module two_queue_timestamp_merge
    import tsm_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   opcode,
    input  logic signed [PTS_PORT_W-1:0] pts,
    input  logic [HANDLE_W-1:0]          frame_handle,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         found,
    output logic [1:0]                   media_kind,
    output logic [HANDLE_W-1:0]          handle_out,
    output logic signed [PTS_PORT_W-1:0] pts_out,
    output logic                         dropped,
    output logic [6:0]                   audio_count,
    output logic [6:0]                   video_count,
    output logic [7:0]                   total_count,
    output logic                         any_pending,
    input  logic                         cfg_write,
    input  logic [SCALE_W-1:0]           cfg_data
);

    cmd_t cmd;
    sts_t sts;

    tsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tsm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (opcode),
        .pts          (pts),
        .frame_handle (frame_handle),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .media_kind   (media_kind),
        .handle_out   (handle_out),
        .pts_out      (pts_out),
        .dropped      (dropped),
        .audio_count  (audio_count),
        .video_count  (video_count),
        .total_count  (total_count),
        .any_pending  (any_pending)
    );

endmodule

// ===== rtl/core/tsm_ram.sv =====
// tsm_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/tsm_ctrl.sv =====
// tsm_ctrl: sequencer for push search/shift and pop compare/shift
// depends on tsm_pkg
`timescale 1ns / 1ps

module tsm_ctrl
    import tsm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority if (sts.op == OP_PUSH_A || sts.op == OP_PUSH_V)
                begin
                    state_next = ST_SRCH;
                end
                else if (sts.op == OP_POP)
                begin
                    state_next = ST_POP_RD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SRCH:
            begin
                state_next = sts.srch_done ? ST_CHK : ST_SRCH_CMP;
            end
            ST_SRCH_CMP:
            begin
                state_next = ST_SRCH;
            end
            ST_CHK:
            begin
                priority if (sts.pos_lt_fill)
                begin
                    state_next = ST_CHK_CMP;
                end
                else if (sts.full)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_CHK_CMP:
            begin
                priority if (sts.key_eq || sts.full)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (sts.shift_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_POP_RD:
            begin
                state_next = ST_POP_MUL;
            end
            ST_POP_MUL:
            begin
                state_next = ST_POP_PICK;
            end
            ST_POP_PICK:
            begin
                state_next = sts.pop_any ? ST_POP_SHIFT : ST_FINISH;
            end
            ST_POP_SHIFT:
            begin
                if (sts.pop_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DECODE:
            begin
                cmd.srch_init = (sts.op == OP_PUSH_A || sts.op == OP_PUSH_V);
            end
            ST_SRCH:
            begin
                cmd.srch_read = !sts.srch_done;
            end
            ST_SRCH_CMP:
            begin
                cmd.srch_upd = 1'b1;
            end
            ST_CHK:
            begin
                priority if (sts.pos_lt_fill)
                begin
                    cmd.chk_read = 1'b1;
                end
                else if (sts.full)
                begin
                    cmd.set_drop = 1'b1;
                end
                else
                begin
                    cmd.shift_init = 1'b1;
                end
            end
            ST_CHK_CMP:
            begin
                priority if (sts.key_eq)
                begin
                    cmd.ovr_write = 1'b1;
                end
                else if (sts.full)
                begin
                    cmd.set_drop = 1'b1;
                end
                else
                begin
                    cmd.shift_init = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                cmd.insert     = sts.shift_done;
                cmd.shift_step = !sts.shift_done;
            end
            ST_POP_RD:
            begin
                cmd.pop_read = 1'b1;
            end
            ST_POP_MUL:
            begin
                cmd.pop_mul = 1'b1;
            end
            ST_POP_PICK:
            begin
                cmd.pop_pick = 1'b1;
            end
            ST_POP_SHIFT:
            begin
                cmd.pop_dec  = sts.pop_done;
                cmd.pop_step = !sts.pop_done;
            end
            ST_FINISH:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/tsm_dp.sv =====
// tsm_dp: stores, fill counts, binary search, shift pipeline, pop compare, result register
// depends on tsm_pkg and tsm_ram
`timescale 1ns / 1ps

module tsm_dp
    import tsm_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cmd_t                         cmd,
    output sts_t                         sts,
    input  logic [1:0]                   opcode,
    input  logic signed [PTS_PORT_W-1:0] pts,
    input  logic [HANDLE_W-1:0]          frame_handle,
    input  logic                         cfg_write,
    input  logic [SCALE_W-1:0]           cfg_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         found,
    output logic [1:0]                   media_kind,
    output logic [HANDLE_W-1:0]          handle_out,
    output logic signed [PTS_PORT_W-1:0] pts_out,
    output logic                         dropped,
    output logic [6:0]                   audio_count,
    output logic [6:0]                   video_count,
    output logic [7:0]                   total_count,
    output logic                         any_pending
);

    logic [1:0]                op_reg;
    logic [PTS_W-1:0]          key_reg;
    logic [HANDLE_W-1:0]       hnd_reg;
    logic                      sel_reg, sel_next;
    logic [CNT_W-1:0]          fill_a_reg, fill_a_next;
    logic [CNT_W-1:0]          fill_v_reg, fill_v_next;
    logic [CNT_W-1:0]          lo_reg, lo_next;
    logic [CNT_W-1:0]          hi_reg, hi_next;
    logic [CNT_W-1:0]          ptr_reg, ptr_next;
    logic                      pend_reg, pend_next;
    logic [IDX_W-1:0]          pend_addr_reg, pend_addr_next;
    logic [SCALE_W-1:0]        scale_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [ENTRY_W-1:0]        ahead_reg;
    logic [ENTRY_W-1:0]        vhead_reg;
    logic                      res_found_reg;
    logic [1:0]                res_kind_reg;
    logic [ENTRY_W-1:0]        res_entry_reg;
    logic                      res_drop_reg;
    logic                      out_valid_reg;
    logic                      out_found_reg;
    logic [1:0]                out_kind_reg;
    logic [ENTRY_W-1:0]        out_entry_reg;
    logic                      out_drop_reg;
    logic [CNT_W-1:0]          out_fa_reg;
    logic [CNT_W-1:0]          out_fv_reg;

    logic [IDX_W-1:0]   raddr;
    logic               we_a, we_v;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] a_rdata, v_rdata, rdata_sel;
    logic [PTS_W-1:0]   rkey;
    logic [CNT_W-1:0]   fill_sel;
    logic [CNT_W:0]     mid_sum;
    logic [CNT_W-1:0]   mid;
    logic               wr_en;
    logic               a_wins;
    logic signed [PROD_W-1:0] akey_ext;

    tsm_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_audio_ram (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (a_rdata)
    );

    tsm_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_video_ram (
        .clk   (clk),
        .we    (we_v),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (v_rdata)
    );

    assign fill_sel  = sel_reg ? fill_v_reg : fill_a_reg;
    assign rdata_sel = sel_reg ? v_rdata : a_rdata;
    assign rkey      = rdata_sel[ENTRY_W-1:HANDLE_W];
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[CNT_W:1];
    assign akey_ext  = PROD_W'($signed(ahead_reg[ENTRY_W-1:HANDLE_W]));
    assign a_wins    = (fill_a_reg != '0) &&
                       ((fill_v_reg == '0) || (akey_ext < prod_reg));

    assign sts.op          = op_reg;
    assign sts.srch_done   = (lo_reg == hi_reg);
    assign sts.pos_lt_fill = (lo_reg < fill_sel);
    assign sts.key_eq      = (rkey == key_reg);
    assign sts.full        = (fill_sel == CNT_W'(CAPACITY));
    assign sts.shift_done  = (ptr_reg == lo_reg) && !pend_reg;
    assign sts.pop_any     = (fill_a_reg != '0) || (fill_v_reg != '0);
    assign sts.pop_done    = (ptr_reg >= fill_sel) && !pend_reg;
    assign sts.out_free    = !out_valid_reg || out_ready;

    // ram port steering
    always_comb
    begin
        raddr          = '0;
        wr_en          = 1'b0;
        waddr          = lo_reg[IDX_W-1:0];
        wdata          = {key_reg, hnd_reg};
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        sel_next       = sel_reg;
        fill_a_next    = fill_a_reg;
        fill_v_next    = fill_v_reg;
        if (cmd.load)
        begin
            sel_next = (opcode == OP_PUSH_V);
        end
        if (cmd.srch_init)
        begin
            lo_next = '0;
            hi_next = fill_sel;
        end
        if (cmd.srch_read)
        begin
            raddr = mid[IDX_W-1:0];
        end
        if (cmd.srch_upd)
        begin
            if ($signed(rkey) < $signed(key_reg))
            begin
                lo_next = mid + CNT_W'(1);
            end
            else
            begin
                hi_next = mid;
            end
        end
        if (cmd.chk_read)
        begin
            raddr = lo_reg[IDX_W-1:0];
        end
        if (cmd.ovr_write || cmd.insert)
        begin
            wr_en = 1'b1;
        end
        if (cmd.shift_init)
        begin
            ptr_next  = fill_sel;
            pend_next = 1'b0;
        end
        if (cmd.shift_step)
        begin
            if (pend_reg)
            begin
                wr_en = 1'b1;
                waddr = pend_addr_reg;
                wdata = rdata_sel;
            end
            if (ptr_reg > lo_reg)
            begin
                raddr          = IDX_W'(ptr_reg - CNT_W'(1));
                pend_next      = 1'b1;
                pend_addr_next = ptr_reg[IDX_W-1:0];
                ptr_next       = ptr_reg - CNT_W'(1);
            end
            else
            begin
                pend_next = 1'b0;
            end
        end
        if (cmd.insert)
        begin
            if (sel_reg)
            begin
                fill_v_next = fill_v_reg + CNT_W'(1);
            end
            else
            begin
                fill_a_next = fill_a_reg + CNT_W'(1);
            end
        end
        // both heads sit at entry zero
        if (cmd.pop_read)
        begin
            raddr = '0;
        end
        if (cmd.pop_pick)
        begin
            sel_next  = !a_wins;
            ptr_next  = CNT_W'(1);
            pend_next = 1'b0;
        end
        if (cmd.pop_step)
        begin
            if (pend_reg)
            begin
                wr_en = 1'b1;
                waddr = pend_addr_reg;
                wdata = rdata_sel;
            end
            if (ptr_reg < fill_sel)
            begin
                raddr          = ptr_reg[IDX_W-1:0];
                pend_next      = 1'b1;
                pend_addr_next = IDX_W'(ptr_reg - CNT_W'(1));
                ptr_next       = ptr_reg + CNT_W'(1);
            end
            else
            begin
                pend_next = 1'b0;
            end
        end
        if (cmd.pop_dec)
        begin
            if (sel_reg)
            begin
                fill_v_next = fill_v_reg - CNT_W'(1);
            end
            else
            begin
                fill_a_next = fill_a_reg - CNT_W'(1);
            end
        end
    end

    assign we_a = wr_en && !sel_reg;
    assign we_v = wr_en && sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_a_reg    <= '0;
            fill_v_reg    <= '0;
            pend_reg      <= 1'b0;
            scale_reg     <= SCALE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_a_reg <= fill_a_next;
            fill_v_reg <= fill_v_next;
            pend_reg   <= pend_next;
            if (cfg_write)
            begin
                scale_reg <= cfg_data;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        sel_reg       <= sel_next;
        if (cmd.load)
        begin
            op_reg        <= opcode;
            key_reg       <= pts[PTS_W-1:0];
            hnd_reg       <= frame_handle;
            res_found_reg <= 1'b0;
            res_kind_reg  <= KIND_NONE;
            res_entry_reg <= '0;
            res_drop_reg  <= 1'b0;
        end
        if (cmd.set_drop)
        begin
            res_drop_reg <= 1'b1;
        end
        if (cmd.pop_mul)
        begin
            ahead_reg <= a_rdata;
            vhead_reg <= v_rdata;
            prod_reg  <= PROD_W'($signed(v_rdata[ENTRY_W-1:HANDLE_W])) *
                         $signed({1'b0, scale_reg});
        end
        if (cmd.pop_pick && sts.pop_any)
        begin
            res_found_reg <= 1'b1;
            res_kind_reg  <= a_wins ? KIND_AUDIO : KIND_VIDEO;
            res_entry_reg <= a_wins ? ahead_reg : vhead_reg;
        end
        if (cmd.finish)
        begin
            out_found_reg <= res_found_reg;
            out_kind_reg  <= res_kind_reg;
            out_entry_reg <= res_entry_reg;
            out_drop_reg  <= res_drop_reg;
            out_fa_reg    <= fill_a_reg;
            out_fv_reg    <= fill_v_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign media_kind  = out_kind_reg;
    assign handle_out  = out_entry_reg[HANDLE_W-1:0];
    assign pts_out     = PTS_PORT_W'($signed(out_entry_reg[ENTRY_W-1:HANDLE_W]));
    assign dropped     = out_drop_reg;
    assign audio_count = 7'(out_fa_reg);
    assign video_count = 7'(out_fv_reg);
    assign total_count = 8'({1'b0, out_fa_reg} + {1'b0, out_fv_reg});
    assign any_pending = (out_fa_reg != '0) || (out_fv_reg != '0);

endmodule

// ===== rtl/core/tsm_checker.sv =====
// tsm_checker: port level assertions for two_queue_timestamp_merge, bound to the top level
// depends on tsm_pkg
`timescale 1ns / 1ps

module tsm_checker
    import tsm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  found,
    input logic [1:0]            media_kind,
    input logic [HANDLE_W-1:0]   handle_out,
    input logic                  dropped,
    input logic [6:0]            audio_count,
    input logic [6:0]            video_count,
    input logic [7:0]            total_count,
    input logic                  any_pending
);

    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> total_count == 8'({1'b0, audio_count} + {1'b0, video_count}))
        else $error("total count mismatch");

    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> any_pending == (total_count != 8'd0))
        else $error("pending flag mismatch");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> found == (media_kind != KIND_NONE))
        else $error("found and media kind disagree");

    a_found_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> !dropped)
        else $error("pop result flagged as dropped");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(handle_out))
        else $error("result changed while stalled");

endmodule

bind two_queue_timestamp_merge tsm_checker u_tsm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .media_kind  (media_kind),
    .handle_out  (handle_out),
    .dropped     (dropped),
    .audio_count (audio_count),
    .video_count (video_count),
    .total_count (total_count),
    .any_pending (any_pending)
);
